### design/plir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plir_pkg
// Shared types and constants of the piecewise-linear intensity remap.
// ----------------------------------------------------------------------------
package plir_pkg;

    // field and register widths
    localparam int VOX_W     = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int PC_W      = 4;

    // default number of breakpoints held
    localparam int MAX_POINTS_DEF = 8;

    // register reset values
    localparam logic [PC_W-1:0] PC_RESET     = 4'd2;
    localparam logic [15:0]     POINTS_RESET = 16'hFF00;

    // queue depths and divider length
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 16;
    localparam int DIV_STEPS = VOX_W;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POINT_COUNT   = 2'd0,
        CFG_INPUT_POINTS  = 2'd1,
        CFG_OUTPUT_POINTS = 2'd2
    } t_cfg_idx;

    // classified voxel, handed from front to back
    typedef struct packed {
        logic             direct;
        logic             neg;
        logic [VOX_W-1:0] o0;
        logic [VOX_W-1:0] mag;
        logic [VOX_W-1:0] dv;
        logic [VOX_W-1:0] den;
    } t_mid;

    // one stage of the division pipeline
    typedef struct packed {
        logic             direct;
        logic             neg;
        logic [VOX_W-1:0] o0;
        logic [VOX_W-1:0] den;
        logic [VOX_W-1:0] rem;
        logic [VOX_W-1:0] nq;
    } t_div;

endpackage

### design/plir_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plir_fifo
// Small synchronous queue with registered pointers and fill count.
// ----------------------------------------------------------------------------
module plir_fifo #(
    parameter int WIDTH = plir_pkg::VOX_W,
    parameter int DEPTH = plir_pkg::MID_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### design/plir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plir_front
// Classifies a voxel against the breakpoints: picks the segment or a direct
// output level, and prepares the operands of the interpolation.
// ----------------------------------------------------------------------------
module plir_front #(
    parameter int MAX_POINTS = plir_pkg::MAX_POINTS_DEF
) (
    input  logic [plir_pkg::VOX_W-1:0]            i_voxel_in,
    input  logic [plir_pkg::PC_W-1:0]             i_point_count,
    input  logic [MAX_POINTS*plir_pkg::VOX_W-1:0] i_input_points,
    input  logic [MAX_POINTS*plir_pkg::VOX_W-1:0] i_output_points,
    output plir_pkg::t_mid                        o_entry
);
    import plir_pkg::*;

    logic [PC_W-1:0]  n_used;
    logic [VOX_W-1:0] raw_first;
    logic [VOX_W-1:0] out_first;
    logic [VOX_W-1:0] raw_last;
    logic [VOX_W-1:0] out_last;
    logic             found;
    logic [VOX_W-1:0] r0;
    logic [VOX_W-1:0] r1;
    logic [VOX_W-1:0] o0;
    logic [VOX_W-1:0] o1;

    // points in use, clamped to the supported range
    always_comb begin
        if (i_point_count < PC_W'(2)) begin
            n_used = PC_W'(2);
        end else if (i_point_count > PC_W'(MAX_POINTS)) begin
            n_used = PC_W'(MAX_POINTS);
        end else begin
            n_used = i_point_count;
        end
    end

    // first and last breakpoint in use
    always_comb begin
        raw_first = i_input_points[VOX_W-1:0];
        out_first = i_output_points[VOX_W-1:0];
        raw_last  = i_input_points[VOX_W-1:0];
        out_last  = i_output_points[VOX_W-1:0];
        for (int i = 1; i < MAX_POINTS; i++) begin
            if (i == int'(n_used) - 1) begin
                raw_last = i_input_points[i*VOX_W +: VOX_W];
                out_last = i_output_points[i*VOX_W +: VOX_W];
            end
        end
    end

    // last segment whose closed interval holds the voxel
    always_comb begin
        found = 1'b0;
        r0    = '0;
        r1    = '0;
        o0    = '0;
        o1    = '0;
        for (int m = 0; m < MAX_POINTS - 1; m++) begin
            if ((m + 1) < int'(n_used)
                && i_voxel_in >= i_input_points[m*VOX_W +: VOX_W]
                && i_voxel_in <= i_input_points[(m+1)*VOX_W +: VOX_W]) begin
                found = 1'b1;
                r0    = i_input_points[m*VOX_W +: VOX_W];
                r1    = i_input_points[(m+1)*VOX_W +: VOX_W];
                o0    = i_output_points[m*VOX_W +: VOX_W];
                o1    = i_output_points[(m+1)*VOX_W +: VOX_W];
            end
        end
    end

    // direct level or interpolation operands
    always_comb begin
        o_entry.direct = 1'b1;
        o_entry.neg    = (o1 < o0);
        o_entry.o0     = o0;
        o_entry.mag    = (o1 < o0) ? (o0 - o1) : (o1 - o0);
        o_entry.dv     = i_voxel_in - r0;
        o_entry.den    = r1 - r0;
        if (i_voxel_in < raw_first) begin
            o_entry.o0 = out_first;
        end else if (i_voxel_in > raw_last || !found) begin
            o_entry.o0 = out_last;
        end else if (r0 != r1) begin
            o_entry.direct = 1'b0;
        end
    end

endmodule

### design/plir_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plir_back
// Interpolation pipeline: one multiply stage, a restoring divider of one
// quotient bit a stage, and floor correction at the end.
// ----------------------------------------------------------------------------
module plir_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  plir_pkg::t_mid             i_entry,
    output logic                       o_valid,
    output logic [plir_pkg::VOX_W-1:0] o_voxel_out
);
    import plir_pkg::*;

    logic [DIV_STEPS:0]   r_vld;
    t_div                 r_div [DIV_STEPS+1];
    t_div                 n_div [DIV_STEPS+1];
    logic [2*VOX_W-1:0]   product;
    logic                 bump;
    logic [VOX_W:0]       quot;
    logic [VOX_W:0]       sum;

    // multiply stage input
    always_comb begin
        product         = {{VOX_W{1'b0}}, i_entry.dv} * {{VOX_W{1'b0}}, i_entry.mag};
        n_div[0].direct = i_entry.direct;
        n_div[0].neg    = i_entry.neg;
        n_div[0].o0     = i_entry.o0;
        n_div[0].den    = i_entry.den;
        n_div[0].rem    = product[2*VOX_W-1:VOX_W];
        n_div[0].nq     = product[VOX_W-1:0];
    end

    // one quotient bit per stage
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [VOX_W:0] trial;
        logic           ge;
        always_comb begin
            trial = {r_div[g].rem, r_div[g].nq[VOX_W-1]};
            ge    = (trial >= {1'b0, r_div[g].den});
            n_div[g+1]     = r_div[g];
            n_div[g+1].rem = ge ? VOX_W'(trial - {1'b0, r_div[g].den}) : trial[VOX_W-1:0];
            n_div[g+1].nq  = {r_div[g].nq[VOX_W-2:0], ge};
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DIV_STEPS-1:0], i_valid};
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        for (int i = 0; i <= DIV_STEPS; i++) begin
            r_div[i] <= n_div[i];
        end
    end

    // floor toward minus infinity on a falling segment, then add or subtract
    always_comb begin
        bump = r_div[DIV_STEPS].neg && (r_div[DIV_STEPS].rem != '0);
        quot = {1'b0, r_div[DIV_STEPS].nq} + {{VOX_W{1'b0}}, bump};
        sum  = r_div[DIV_STEPS].neg ? ({1'b0, r_div[DIV_STEPS].o0} - quot)
                                    : ({1'b0, r_div[DIV_STEPS].o0} + quot);
        o_voxel_out = r_div[DIV_STEPS].direct ? r_div[DIV_STEPS].o0 : sum[VOX_W-1:0];
    end

    assign o_valid = r_vld[DIV_STEPS];

endmodule

### design/piecewise_linear_intensity_remap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_intensity_remap_top
// Remaps 8-bit voxels through a piecewise-linear transfer curve.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue: drive i_voxel_in with i_push while o_full is low.
//   Result side is a queue: o_voxel_out holds the oldest result while o_empty
//   is low; i_pop takes it.
//   Configuration: i_cfg_we with i_cfg_index (0 point count, 1 raw points,
//   2 output levels) and i_cfg_data; write only while the block is idle.
// Timing:
//   Throughput is one voxel per clock while no credit or queue stall holds
//   issue, set by the interpolation pipeline (one multiply stage, eight
//   divider stages of one quotient bit each). Each voxel passes the classified
//   queue, the multiply stage and the divider stages, then enters the result queue.
//   Issue into the pipeline is gated by a credit count against the 16-entry
//   result queue, so a stalled receiver fills that queue, then the 4-entry
//   classified queue, and then o_full rises; nothing is dropped.
// Reset:
//   Synchronous, active low; empties both queues and the pipeline and loads
//   two breakpoints mapping 0..255 onto 0..255.
// ----------------------------------------------------------------------------
module piecewise_linear_intensity_remap_top #(
    parameter int MAX_POINTS = plir_pkg::MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [plir_pkg::VOX_W-1:0]     i_voxel_in,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic [plir_pkg::VOX_W-1:0]     o_voxel_out,
    input  logic                           i_cfg_we,
    input  logic [plir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plir_pkg::CFG_W-1:0]     i_cfg_data
);
    import plir_pkg::*;

    localparam int PW = MAX_POINTS * VOX_W;
    localparam int MW = $bits(t_mid);
    localparam int CRW = $clog2(OUT_DEPTH + 1);

    logic [PC_W-1:0]  r_point_count;
    logic [PW-1:0]    r_input_points;
    logic [PW-1:0]    r_output_points;
    logic [CRW-1:0]   r_credit;

    t_mid             front_entry;
    t_mid             mid_head;
    logic [MW-1:0]    mid_wdata;
    logic [MW-1:0]    mid_rdata;
    logic             mid_empty;
    logic             issue;
    logic             back_valid;
    logic [VOX_W-1:0] back_voxel;
    logic             out_full;
    logic             out_pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count   <= PC_RESET;
            r_input_points  <= PW'(POINTS_RESET);
            r_output_points <= PW'(POINTS_RESET);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_POINT_COUNT:   r_point_count   <= i_cfg_data[PC_W-1:0];
                CFG_INPUT_POINTS:  r_input_points  <= i_cfg_data[PW-1:0];
                CFG_OUTPUT_POINTS: r_output_points <= i_cfg_data[PW-1:0];
                default: ;
            endcase
        end
    end

    // front: classify the incoming voxel
    plir_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_voxel_in     (i_voxel_in),
        .i_point_count  (r_point_count),
        .i_input_points (r_input_points),
        .i_output_points(r_output_points),
        .o_entry        (front_entry)
    );

    assign mid_wdata = front_entry;
    assign mid_head  = t_mid'(mid_rdata);

    // queue between front and back
    plir_fifo #(
        .WIDTH(MW),
        .DEPTH(MID_DEPTH)
    ) u_mid_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_data (mid_wdata),
        .o_full (o_full),
        .i_pop  (issue),
        .o_data (mid_rdata),
        .o_empty(mid_empty)
    );

    // issue only with a free result slot reserved
    assign issue   = !mid_empty && (r_credit < CRW'(OUT_DEPTH));
    assign out_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else if (issue && !out_pop) begin
            r_credit <= r_credit + 1'b1;
        end else if (out_pop && !issue) begin
            r_credit <= r_credit - 1'b1;
        end
    end

    // back: interpolation pipeline
    plir_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (issue),
        .i_entry    (mid_head),
        .o_valid    (back_valid),
        .o_voxel_out(back_voxel)
    );

    // result queue
    plir_fifo #(
        .WIDTH(VOX_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (back_valid),
        .i_data (back_voxel),
        .o_full (out_full),
        .i_pop  (i_pop),
        .o_data (o_voxel_out),
        .o_empty(o_empty)
    );

`ifndef SYNTHESIS
    // a finished result always finds room in the result queue
    a_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_valid |-> !out_full)
        else $error("result queue overflow");

    // credits never exceed the result queue depth
    a_credit_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(OUT_DEPTH))
        else $error("credit count out of range");

    // a waiting result is always covered by a credit
    a_credit_cover : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (r_credit != '0))
        else $error("result without credit");

    // an issue with no pop raises the credit count by one
    a_credit_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && !out_pop) |=> (r_credit == $past(r_credit) + 1'b1))
        else $error("credit count did not follow issue");
`endif

endmodule

### sim/remap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// remap_checker
// Watches the voxel, result and configuration channels of the intensity
// remap. Keeps its own copy of the transfer curve, predicts the remapped
// level of every accepted voxel and checks results strictly in order.
// ----------------------------------------------------------------------------
module remap_checker #(
    parameter int MAX_POINTS = plir_pkg::MAX_POINTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [plir_pkg::VOX_W-1:0]     i_voxel_in,
    input  logic                           i_empty,
    input  logic                           i_pop,
    input  logic [plir_pkg::VOX_W-1:0]     i_voxel_out,
    input  logic                           i_cfg_we,
    input  logic [plir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [plir_pkg::CFG_W-1:0]     i_cfg_data,
    output int                             o_pending,
    output int                             o_fail_count
);
    import plir_pkg::*;

    // shadow copy of the transfer curve
    logic [PC_W-1:0]  curve_count;
    logic [CFG_W-1:0] curve_raw;
    logic [CFG_W-1:0] curve_level;

    // predicted levels still waiting for their result transaction
    logic [VOX_W-1:0] level_queue[$];
    int               waiting    = 0;
    int               mismatches = 0;

    assign o_pending    = waiting;
    assign o_fail_count = mismatches;

    // one 8-bit breakpoint out of a packed register
    function automatic int point_of(input logic [CFG_W-1:0] packed_pts, input int i);
        return int'(packed_pts[VOX_W*i +: VOX_W]);
    endfunction

    // remapped level of one voxel under the current curve
    function automatic logic [VOX_W-1:0] remap_intensity(input logic [VOX_W-1:0] voxel);
        int n;
        int top_pt;
        int v;
        int seg;
        int r0;
        int r1;
        int o0;
        int o1;
        int num;
        int den;
        int lvl;
        bit hit;
        n = int'(curve_count);
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        top_pt = n - 1;
        v = int'(voxel);
        seg = 0;
        hit = 1'b0;
        if (v < point_of(curve_raw, 0)) begin
            // below the first breakpoint, also when above the last one
            lvl = point_of(curve_level, 0);
        end else if (v > point_of(curve_raw, top_pt)) begin
            lvl = point_of(curve_level, top_pt);
        end else begin
            // last segment whose closed interval holds the voxel
            for (int m = 0; m < top_pt; m++) begin
                if (v >= point_of(curve_raw, m) && v <= point_of(curve_raw, m + 1)) begin
                    seg = m;
                    hit = 1'b1;
                end
            end
            if (!hit) begin
                lvl = point_of(curve_level, top_pt);
            end else begin
                r0 = point_of(curve_raw, seg);
                r1 = point_of(curve_raw, seg + 1);
                o0 = point_of(curve_level, seg);
                o1 = point_of(curve_level, seg + 1);
                if (r1 == r0) begin
                    // zero-width segment keeps its lower level
                    lvl = o0;
                end else begin
                    num = (v - r0) * (o1 - o0);
                    den = r1 - r0;
                    // quotient floored toward minus infinity
                    if (num >= 0) lvl = o0 + num / den;
                    else lvl = o0 - ((-num + den - 1) / den);
                end
            end
        end
        if (lvl < 0) lvl = 0;
        if (lvl > 255) lvl = 255;
        return lvl[VOX_W-1:0];
    endfunction

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t remap result %s: expected %0d, got %0d", $time, what, want, got);
        mismatches++;
    endtask

    // watch all three channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            curve_count <= PC_RESET;
            curve_raw   <= CFG_W'(POINTS_RESET);
            curve_level <= CFG_W'(POINTS_RESET);
            level_queue.delete();
            waiting <= 0;
        end else begin
            // result transaction against the oldest prediction
            if (i_pop && !i_empty) begin
                if (level_queue.size() == 0) begin
                    report_mismatch("with nothing outstanding", -1, int'(i_voxel_out));
                end else begin
                    if (i_voxel_out !== level_queue[0])
                        report_mismatch("voxel_out", int'(level_queue[0]),
                                        int'(i_voxel_out));
                    void'(level_queue.pop_front());
                end
            end
            // voxel transaction
            if (i_push && !i_full)
                level_queue.push_back(remap_intensity(i_voxel_in));
            // register writes
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_POINT_COUNT:   curve_count <= i_cfg_data[PC_W-1:0];
                    CFG_INPUT_POINTS:  curve_raw   <= i_cfg_data;
                    CFG_OUTPUT_POINTS: curve_level <= i_cfg_data;
                    default: ;
                endcase
            end
            waiting <= level_queue.size();
        end
    end

endmodule

### sim/piecewise_linear_intensity_remap_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_intensity_remap_top_test
// Drives voxels through the remap under a series of transfer curves, from
// hand-picked corner curves to random ones, with random gaps on the input
// side and random stalls on the result side. Checking is done by the
// remap_checker instance; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module piecewise_linear_intensity_remap_top_test;
    import plir_pkg::*;

    localparam int N_PHASES        = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int DRAIN_CYCLES    = 16;
    localparam int END_CYCLES      = 24;
    localparam int STALL_LIMIT     = 2000;

    // block ports, the inputs all known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_push      = 1'b0;
    logic [VOX_W-1:0]     i_voxel_in  = '0;
    logic                 i_pop       = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_POINT_COUNT;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 o_full;
    logic                 o_empty;
    logic [VOX_W-1:0]     o_voxel_out;

    int pending;
    int fail_count;

    // stimulus shaping state
    logic [PC_W-1:0]  stim_count = PC_RESET;
    logic [CFG_W-1:0] stim_raw   = CFG_W'(POINTS_RESET);
    logic             tx_steady  = 1'b0;
    logic             rx_steady  = 1'b0;
    int               rx_hold    = 0;
    int               quiet_cycles = 0;

    piecewise_linear_intensity_remap_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_voxel_in  (i_voxel_in),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_voxel_out (o_voxel_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    remap_checker remap_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_full       (o_full),
        .i_voxel_in   (i_voxel_in),
        .i_empty      (o_empty),
        .i_pop        (i_pop),
        .i_voxel_out  (o_voxel_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stalls, mostly short, now and then long
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            i_pop <= 1'b0;
            rx_hold--;
        end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
            i_pop <= 1'b0;
            if ($urandom_range(0, 9) == 0) rx_hold = $urandom_range(10, 40);
            else rx_hold = $urandom_range(0, 2);
        end else begin
            i_pop <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_push && !o_full) || (i_pop && !o_empty) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("piecewise_linear_intensity_remap_top_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // input gap length, mostly none or short
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // voxel near a breakpoint in use, or anywhere
    function automatic logic [VOX_W-1:0] next_voxel();
        int n;
        int k;
        logic [VOX_W-1:0] v;
        n = int'(stim_count);
        if (n < 2) n = 2;
        if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
        if ($urandom_range(0, 9) < 4) begin
            k = $urandom_range(0, n - 1);
            v = stim_raw[VOX_W*k +: VOX_W] + VOX_W'($urandom_range(0, 2)) - VOX_W'(1);
        end else begin
            v = VOX_W'($urandom_range(0, 255));
        end
        return v;
    endfunction

    // hold until every predicted result has been taken
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // one voxel transaction after an optional gap
    task automatic send_voxel(input logic [VOX_W-1:0] v, input int gap);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push     <= 1'b1;
        i_voxel_in <= v;
        do @(posedge i_clk); while (o_full);
    endtask

    // load a whole curve while the block is idle
    task automatic load_curve(input logic [PC_W-1:0] cnt, input logic [CFG_W-1:0] raw,
                              input logic [CFG_W-1:0] lvl);
        logic [CFG_W-1:0] cnt_word;
        i_push <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        // upper bits of the count word carry noise
        cnt_word = {$urandom, $urandom};
        cnt_word[PC_W-1:0] = cnt;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_POINT_COUNT;
        i_cfg_data  <= cnt_word;
        @(posedge i_clk);
        i_cfg_index <= CFG_INPUT_POINTS;
        i_cfg_data  <= raw;
        @(posedge i_clk);
        i_cfg_index <= CFG_OUTPUT_POINTS;
        i_cfg_data  <= lvl;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        stim_count = cnt;
        stim_raw   = raw;
    endtask

    // stimulus and verdict
    initial begin
        logic [VOX_W-1:0] pt[MAX_POINTS_DEF];
        logic [VOX_W-1:0] swap;
        logic [PC_W-1:0]  cnt;
        logic [CFG_W-1:0] raw;
        logic [CFG_W-1:0] lvl;
        int               j;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset curve is the identity
        send_voxel(8'd0, 0);
        send_voxel(8'd255, 0);
        send_voxel(8'h55, 1);
        send_voxel(8'hAA, 0);

        // eight points, falling slope, zero-width last segment
        load_curve(4'd8, 64'hFAFA_C896_5A28_280A, 64'hFF07_DCDC_1E64_00FF);
        send_voxel(8'd0, 0);
        send_voxel(8'd10, 0);
        send_voxel(8'd25, 0);
        send_voxel(8'd40, 2);
        send_voxel(8'd65, 0);
        send_voxel(8'd100, 0);
        send_voxel(8'd175, 0);
        send_voxel(8'd249, 0);
        send_voxel(8'd250, 3);
        send_voxel(8'd251, 0);
        send_voxel(8'd255, 0);

        // count above the maximum, breakpoints out of order
        load_curve(4'd15, 64'hE605_FA64_8C3C_B414, 64'h03FF_5A32_C80A_FF00);
        send_voxel(8'd10, 0);
        send_voxel(8'd240, 0);
        send_voxel(8'd150, 0);
        send_voxel(8'd20, 0);
        send_voxel(8'd230, 0);

        // count below two, first breakpoint above the last
        load_curve(4'd0, 64'h0123_4567_89AB_64C8, 64'hFEDC_BA98_7654_214D);
        send_voxel(8'd150, 0);
        send_voxel(8'd250, 0);
        send_voxel(8'd50, 0);

        // random curves, the extremes among them
        for (int phase = 0; phase < N_PHASES; phase++) begin
            for (int k = 0; k < MAX_POINTS_DEF; k++) pt[k] = VOX_W'($urandom_range(0, 255));
            if ($urandom_range(0, 3) != 0) begin
                // well-formed curve, sometimes with repeated breakpoints
                if ($urandom_range(0, 2) == 0) begin
                    j = $urandom_range(0, MAX_POINTS_DEF - 2);
                    pt[j] = pt[j + 1];
                end
                for (int a = 0; a < MAX_POINTS_DEF - 1; a++) begin
                    for (int b = 0; b < MAX_POINTS_DEF - 1 - a; b++) begin
                        if (pt[b] > pt[b + 1]) begin
                            swap = pt[b];
                            pt[b] = pt[b + 1];
                            pt[b + 1] = swap;
                        end
                    end
                end
            end
            for (int k = 0; k < MAX_POINTS_DEF; k++) raw[VOX_W*k +: VOX_W] = pt[k];
            lvl = {$urandom, $urandom};
            if ($urandom_range(0, 3) == 0) cnt = PC_W'($urandom_range(0, 15));
            else cnt = PC_W'($urandom_range(2, 8));
            case (phase)
                0: begin
                    cnt = 4'd8;
                    raw = '0;
                    lvl = '1;
                end
                1: begin
                    cnt = 4'd15;
                    raw = '1;
                    lvl = '0;
                end
                2: begin
                    cnt = 4'd2;
                    raw[15:0] = 16'hFF00;
                end
                3: cnt = 4'd1;
                4: cnt = 4'd8;
                default: ;
            endcase
            load_curve(cnt, raw, lvl);
            tx_steady <= (phase % 4 == 1) || (phase % 5 == 3);
            rx_steady <= (phase % 4 == 2) || (phase % 5 == 3);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // sender holds off until the result side has caught up
                if (phase % 3 == 0 && k == ITEMS_PER_PHASE / 2) begin
                    i_push <= 1'b0;
                    wait_drained();
                end
                send_voxel(next_voxel(), next_gap());
            end
        end

        // drain and let any stray result show up
        i_push <= 1'b0;
        wait_drained();
        repeat (END_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("piecewise_linear_intensity_remap_top_test: clean");
        end else begin
            $display("piecewise_linear_intensity_remap_top_test: errors");
        end
        $finish;
    end

endmodule

### sim.f
design/plir_pkg.sv
design/plir_fifo.sv
design/plir_front.sv
design/plir_back.sv
design/piecewise_linear_intensity_remap_top.sv
sim/remap_checker.sv
sim/piecewise_linear_intensity_remap_top_test.sv
